>>> design/polyrdp_pkg.sv
// Shared types and constants for the polyline simplifier.
// Used by polyrdp_ctrl, polyrdp_dp and polyline_simplify_rdp.
`default_nettype none
package polyrdp_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int IDX_W          = 6;
  localparam int CNT_W          = 7;
  localparam int COORD_W        = 16;
  localparam int TOL_W          = 16;
  localparam int TOL_RESET      = 16;
  localparam int STACK_DEPTH    = 64;
  localparam int SIDX_W         = 6;
  localparam int SP_W           = 7;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int PROD_W         = 2 * DIFF_W;
  localparam int MAG_W          = 34;
  localparam int HALF_W         = MAG_W / 2;
  localparam int PP_W           = MAG_W + HALF_W;
  localparam int ACC_W          = 2 * MAG_W;

  typedef enum logic [1:0] {
    RD_LO,
    RD_HI,
    RD_SCAN,
    RD_LAST
  } rd_sel_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_START,
    ST_POP,
    ST_SEG,
    ST_RLO,
    ST_RHI,
    ST_EWAIT,
    ST_LEN1,
    ST_LEN2,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL0,
    ST_MUL1,
    ST_DECIDE,
    ST_PUSH_R,
    ST_PUSH_L,
    ST_KEEP_RD,
    ST_KEEP_WR,
    ST_LAST_RD,
    ST_LAST_WR
  } state_t;

  typedef struct packed {
    logic    store_wr;
    logic    count_clr;
    logic    seg_init;
    logic    sp_dec;
    logic    seg_latch;
    rd_sel_t rd_sel;
    logic    a_latch;
    logic    d_latch;
    logic    scan_init;
    logic    scan_issue;
    logic    mul_step0;
    logic    mul_step1;
    logic    push_right;
    logic    push_left;
    logic    emit_load;
    logic    emit_last;
  } cmd_t;

  typedef struct packed {
    logic            count_one;
    logic            sp_empty;
    logic            scan_done;
    logic            pipe_busy;
    logic            split_ok;
    logic            out_busy;
    logic [SP_W-1:0] sp;
  } sts_t;

endpackage
`default_nettype wire

>>> design/polyline_simplify_rdp.sv
// Top level of the polyline simplifier; joins polyrdp_ctrl and polyrdp_dp.
// Depends on polyrdp_pkg.
//
// Input channel (in_valid/in_ready): one point per transaction, x and y in
// signed Q11.4. Points load one per cycle. A point with final_point set closes
// the polyline and starts the simplification; in_ready stays low until the
// last kept point has been placed in the output register.
// Output channel (out_valid/out_ready): one kept point per transaction, in
// ascending index order, run_end set on the last. A single output register
// holds each result; while the receiver stalls the scan keeps running and
// stops only at the next point to be emitted.
// Each segment popped from the stack is scanned through the single read
// port of the point store and the five-stage distance pipeline; emitting a
// kept point waits while the output register is still full. Interior points
// scanned total about n*log2(n) for even splits and up to n*n/2 for
// lopsided ones. The user must write tolerance through cfg_we/cfg_data
// only while the block is idle; the block itself does not enforce this.
// Reset (rst, synchronous) empties the point count and stack and sets the
// tolerance to 1.0 (16 in Q11.4); the point store needs no clearing.
`default_nettype none
module polyline_simplify_rdp
  import polyrdp_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        cfg_we,
  input  wire         [TOL_W-1:0]    cfg_data,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  signed [COORD_W-1:0]  point_x,
  input  wire  signed [COORD_W-1:0]  point_y,
  input  wire                        final_point,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic        [IDX_W-1:0]    kept_index,
  output logic signed [COORD_W-1:0]  kept_x,
  output logic signed [COORD_W-1:0]  kept_y,
  output logic                       run_end
);

  cmd_t cmd;
  sts_t sts;

  polyrdp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .final_point (final_point),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  polyrdp_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .point_x    (point_x),
    .point_y    (point_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kept_index (kept_index),
    .kept_x     (kept_x),
    .kept_y     (kept_y),
    .run_end    (run_end)
  );

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sts.sp <= SP_W'(STACK_DEPTH))
    else $error("segment stack overrun");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> !out_valid)
    else $error("pending result overwritten");

  a_store_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.store_wr |-> (in_valid && in_ready))
    else $error("point stored without transaction");

  a_push_pair: assert property (@(posedge clk) disable iff (rst)
    cmd.push_right |=> cmd.push_left)
    else $error("split pushed only one half");

endmodule
`default_nettype wire

>>> design/polyrdp_ctrl.sv
// Controller state machine: load, segment stack walk, scan, split or keep, emit.
// Depends on polyrdp_pkg; drives cmd_t to polyrdp_dp and reads sts_t back.
`default_nettype none
module polyrdp_ctrl
  import polyrdp_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  input  wire  final_point,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:    if (in_valid && final_point) state_next = ST_START;
      ST_START:   state_next = sts.count_one ? ST_LAST_RD : ST_POP;
      ST_POP:     state_next = sts.sp_empty ? ST_LAST_RD : ST_SEG;
      ST_SEG:     state_next = ST_RLO;
      ST_RLO:     state_next = ST_RHI;
      ST_RHI:     state_next = ST_EWAIT;
      ST_EWAIT:   state_next = ST_LEN1;
      ST_LEN1:    state_next = ST_LEN2;
      ST_LEN2:    state_next = ST_SCAN;
      ST_SCAN:    if (sts.scan_done) state_next = ST_DRAIN;
      ST_DRAIN:   if (!sts.pipe_busy) state_next = ST_MUL0;
      ST_MUL0:    state_next = ST_MUL1;
      ST_MUL1:    state_next = ST_DECIDE;
      ST_DECIDE:  state_next = sts.split_ok ? ST_PUSH_R : ST_KEEP_RD;
      ST_PUSH_R:  state_next = ST_PUSH_L;
      ST_PUSH_L:  state_next = ST_POP;
      ST_KEEP_RD: if (!sts.out_busy) state_next = ST_KEEP_WR;
      ST_KEEP_WR: state_next = ST_POP;
      ST_LAST_RD: if (!sts.out_busy) state_next = ST_LAST_WR;
      ST_LAST_WR: state_next = ST_LOAD;
      default:    state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rd_sel = RD_SCAN;
    in_ready = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready     = 1'b1;
        cmd.store_wr = in_valid;
      end
      ST_START:   cmd.seg_init = !sts.count_one;
      ST_POP:     cmd.sp_dec = !sts.sp_empty;
      ST_SEG:     cmd.seg_latch = 1'b1;
      ST_RLO:     cmd.rd_sel = RD_LO;
      ST_RHI: begin
        cmd.rd_sel  = RD_HI;
        cmd.a_latch = 1'b1;
      end
      ST_EWAIT:   cmd.d_latch = 1'b1;
      ST_LEN1:    cmd.scan_init = 1'b1;
      ST_LEN2:    cmd.rd_sel = RD_SCAN;
      ST_SCAN: begin
        cmd.rd_sel     = RD_SCAN;
        cmd.scan_issue = !sts.scan_done;
      end
      ST_DRAIN:   cmd.rd_sel = RD_SCAN;
      ST_MUL0:    cmd.mul_step0 = 1'b1;
      ST_MUL1:    cmd.mul_step1 = 1'b1;
      ST_DECIDE:  cmd.rd_sel = RD_LO;
      ST_PUSH_R:  cmd.push_right = 1'b1;
      ST_PUSH_L:  cmd.push_left = 1'b1;
      ST_KEEP_RD: cmd.rd_sel = RD_LO;
      ST_KEEP_WR: cmd.emit_load = 1'b1;
      ST_LAST_RD: cmd.rd_sel = RD_LAST;
      ST_LAST_WR: begin
        cmd.emit_load = 1'b1;
        cmd.emit_last = 1'b1;
        cmd.count_clr = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> design/polyrdp_dp.sv
// Datapath: point store, segment stack, distance scan pipeline, wide compare
// and output register. Depends on polyrdp_pkg; steered by polyrdp_ctrl.
`default_nettype none
module polyrdp_dp
  import polyrdp_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire                        clk,
  input  wire                        rst,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  wire                        cfg_we,
  input  wire         [TOL_W-1:0]    cfg_data,
  input  wire  signed [COORD_W-1:0]  point_x,
  input  wire  signed [COORD_W-1:0]  point_y,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic        [IDX_W-1:0]    kept_index,
  output logic signed [COORD_W-1:0]  kept_x,
  output logic signed [COORD_W-1:0]  kept_y,
  output logic                       run_end
);

  logic [2*COORD_W-1:0] store [MAX_POINTS];
  logic [2*IDX_W-1:0]   stk   [STACK_DEPTH];

  logic [TOL_W-1:0]     tolerance;
  logic [2*TOL_W-1:0]   tol2;
  logic [CNT_W-1:0]     count;
  logic [SP_W-1:0]      sp;
  logic [IDX_W-1:0]     slot, last_idx, rd_addr, rd_idx;
  logic [2*COORD_W-1:0] rd_data;
  logic [2*IDX_W-1:0]   stk_rdata;
  logic [IDX_W-1:0]     lo, hi, i, best_i;
  logic signed [COORD_W-1:0] rd_x, rd_y, ax, ay;
  logic signed [DIFF_W-1:0]  dx, dy, px, py;
  logic signed [PROD_W-1:0]  dxx, dyy, m1, m2;
  logic [MAG_W-1:0]     len2, best, mag_d, mag_c;
  logic signed [PROD_W:0]    sum_c, dif_c;
  logic                 deg, va, vb, vc, vd, split;
  logic [IDX_W-1:0]     ia, ib, ic, id;
  logic [MAG_W-1:0]     tol_ext;
  logic [HALF_W-1:0]    hb, hl;
  logic [PP_W-1:0]      p_l, p_r;
  logic [ACC_W-1:0]     lhs_acc, rhs_acc;

  assign slot     = (count < CNT_W'(MAX_POINTS)) ? count[IDX_W-1:0]
                                                 : IDX_W'(MAX_POINTS - 1);
  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign rd_x     = rd_data[2*COORD_W-1:COORD_W];
  assign rd_y     = rd_data[COORD_W-1:0];
  assign deg      = (len2 == '0);
  assign tol_ext  = MAG_W'(tol2);

  always_comb begin
    case (cmd.rd_sel)
      RD_LO:   rd_addr = lo;
      RD_HI:   rd_addr = hi;
      RD_SCAN: rd_addr = i;
      RD_LAST: rd_addr = last_idx;
      default: rd_addr = i;
    endcase
  end

  // config and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_W'(TOL_RESET);
      count     <= '0;
      sp        <= '0;
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) tolerance <= cfg_data;
      if (cmd.store_wr) count <= CNT_W'(slot) + CNT_W'(1);
      else if (cmd.count_clr) count <= '0;
      if (cmd.seg_init) sp <= SP_W'(1);
      else if (cmd.sp_dec) sp <= sp - SP_W'(1);
      else if (cmd.push_right || cmd.push_left) sp <= sp + SP_W'(1);
      va <= cmd.scan_issue;
      vb <= va;
      vc <= vb;
      vd <= vc;
      if (cmd.emit_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wr) store[slot] <= {point_x, point_y};
    rd_data <= store[rd_addr];
    rd_idx  <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_init) stk[0] <= {IDX_W'(0), last_idx};
    else if (cmd.push_right) stk[sp[SIDX_W-1:0]] <= {best_i, hi};
    else if (cmd.push_left) stk[sp[SIDX_W-1:0]] <= {lo, best_i};
    stk_rdata <= stk[SIDX_W'(sp - SP_W'(1))];
  end

  // segment endpoints and length
  always_ff @(posedge clk) begin
    tol2 <= tolerance * tolerance;
    if (cmd.seg_latch) begin
      lo <= stk_rdata[2*IDX_W-1:IDX_W];
      hi <= stk_rdata[IDX_W-1:0];
    end
    if (cmd.a_latch) begin
      ax <= rd_x;
      ay <= rd_y;
    end
    if (cmd.d_latch) begin
      dx <= DIFF_W'(rd_x) - DIFF_W'(ax);
      dy <= DIFF_W'(rd_y) - DIFF_W'(ay);
    end
    dxx  <= dx * dx;
    dyy  <= dy * dy;
    len2 <= MAG_W'(dxx) + MAG_W'(dyy);
  end

  // scan pipeline: read, offset, products, magnitude, running maximum
  assign sum_c = (PROD_W+1)'(m1) + (PROD_W+1)'(m2);
  assign dif_c = (PROD_W+1)'(m1) - (PROD_W+1)'(m2);
  assign mag_c = deg ? MAG_W'(sum_c) : (dif_c[PROD_W] ? MAG_W'(-dif_c) : MAG_W'(dif_c));

  always_ff @(posedge clk) begin
    ia <= i;
    ib <= ia;
    ic <= ib;
    id <= ic;
    px <= DIFF_W'(rd_x) - DIFF_W'(ax);
    py <= DIFF_W'(rd_y) - DIFF_W'(ay);
    m1 <= deg ? px * px : dx * py;
    m2 <= deg ? py * py : dy * px;
    mag_d <= mag_c;
    if (cmd.scan_init) begin
      i      <= lo + IDX_W'(1);
      best   <= '0;
      best_i <= '0;
    end else begin
      if (cmd.scan_issue) i <= i + IDX_W'(1);
      if (vd && (mag_d > best)) begin
        best   <= mag_d;
        best_i <= id;
      end
    end
  end

  // best^2 against tol^2 * len^2, two half-width steps
  assign hb  = cmd.mul_step0 ? best[HALF_W-1:0] : best[MAG_W-1:HALF_W];
  assign hl  = cmd.mul_step0 ? len2[HALF_W-1:0] : len2[MAG_W-1:HALF_W];
  assign p_l = best * hb;
  assign p_r = tol_ext * hl;

  always_ff @(posedge clk) begin
    if (cmd.mul_step0) begin
      lhs_acc <= ACC_W'(p_l);
      rhs_acc <= ACC_W'(p_r);
    end else if (cmd.mul_step1) begin
      lhs_acc <= lhs_acc + (ACC_W'(p_l) << HALF_W);
      rhs_acc <= rhs_acc + (ACC_W'(p_r) << HALF_W);
    end
  end

  assign split = deg ? (best > tol_ext) : (lhs_acc > rhs_acc);

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      kept_index <= rd_idx;
      kept_x     <= rd_x;
      kept_y     <= rd_y;
      run_end    <= cmd.emit_last;
    end
  end

  always_comb begin
    sts.count_one = (count == CNT_W'(1));
    sts.sp_empty  = (sp == '0);
    sts.scan_done = (i >= hi);
    sts.pipe_busy = va | vb | vc | vd;
    sts.split_ok  = split && (sp <= SP_W'(STACK_DEPTH - 2));
    sts.out_busy  = out_valid;
    sts.sp        = sp;
  end

endmodule
`default_nettype wire

>>> tb/polyline_simplify_rdp_check.sv
// Checker for polyline_simplify_rdp: watches both channels and the tolerance port,
// predicts the kept points of every polyline and compares them field by field.
// Depends on polyrdp_pkg for field widths.
module polyline_simplify_rdp_check
  import polyrdp_pkg::*;
(
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_we,
  input  wire        [TOL_W-1:0]    cfg_data,
  input  wire                       in_valid,
  input  wire                       in_ready,
  input  wire signed [COORD_W-1:0]  point_x,
  input  wire signed [COORD_W-1:0]  point_y,
  input  wire                       final_point,
  input  wire                       out_valid,
  input  wire                       out_ready,
  input  wire        [IDX_W-1:0]    kept_index,
  input  wire signed [COORD_W-1:0]  kept_x,
  input  wire signed [COORD_W-1:0]  kept_y,
  input  wire                       run_end,
  output int                        errors,
  output int                        pending
);

  typedef struct {
    logic        [IDX_W-1:0]   idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } kept_pt_t;

  kept_pt_t                  kept_q[$];
  logic signed [COORD_W-1:0] store_x[MAX_POINTS_DEF];
  logic signed [COORD_W-1:0] store_y[MAX_POINTS_DEF];
  int                        held;
  logic        [TOL_W-1:0]   tol;

  assign pending = kept_q.size();

  task automatic keep_point(input int i, input bit last);
    kept_pt_t e;
    e.idx  = i[IDX_W-1:0];
    e.x    = store_x[i];
    e.y    = store_y[i];
    e.last = last;
    kept_q = {kept_q, e};
  endtask

  task automatic simplify_polyline();
    int           seg_lo[STACK_DEPTH];
    int           seg_hi[STACK_DEPTH];
    int           sp, lo, hi, best_i, k, i;
    longint       ax, ay, dx, dy, qx, qy, c, len2, m, best, tol2;
    logic [127:0] lhs, rhs;
    bit           degen, split;
    tol2 = longint'(tol) * longint'(tol);
    if (held == 1) begin
      keep_point(0, 1'b1);
      return;
    end
    seg_lo[0] = 0;
    seg_hi[0] = held - 1;
    sp = 1;
    k  = 0;
    while (sp > 0) begin
      sp--;
      lo = seg_lo[sp];
      hi = seg_hi[sp];
      ax = store_x[lo];
      ay = store_y[lo];
      dx = longint'(store_x[hi]) - ax;
      dy = longint'(store_y[hi]) - ay;
      len2 = dx * dx + dy * dy;
      degen = (len2 == 0);
      best = 0;
      best_i = 0;
      for (i = lo + 1; i < hi; i++) begin
        qx = longint'(store_x[i]) - ax;
        qy = longint'(store_y[i]) - ay;
        if (degen) begin
          m = qx * qx + qy * qy;
        end else begin
          c = dx * qy - dy * qx;
          m = (c < 0) ? -c : c;
        end
        if (m > best) begin
          best = m;
          best_i = i;
        end
      end
      if (degen) begin
        split = best > tol2;
      end else begin
        lhs = 128'(best) * 128'(best);
        rhs = 128'(tol2) * 128'(len2);
        split = lhs > rhs;
      end
      if (split && sp + 2 <= STACK_DEPTH) begin
        seg_lo[sp] = best_i;
        seg_hi[sp] = hi;
        sp++;
        seg_lo[sp] = lo;
        seg_hi[sp] = best_i;
        sp++;
      end else if (k < MAX_POINTS_DEF - 1) begin
        keep_point(lo, 1'b0);
        k++;
      end
    end
    keep_point(held - 1, 1'b1);
  endtask

  always @(posedge clk) begin
    kept_pt_t e;
    int       slot;
    if (rst) begin
      held   = 0;
      tol    = TOL_W'(TOL_RESET);
      errors <= 0;
      kept_q.delete();
    end else begin
      if (cfg_we) begin
        tol = cfg_data;
      end
      if (in_valid && in_ready) begin
        slot = (held < MAX_POINTS_DEF) ? held : MAX_POINTS_DEF - 1;
        store_x[slot] = point_x;
        store_y[slot] = point_y;
        held = slot + 1;
        if (final_point) begin
          simplify_polyline();
          held = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (kept_q.size() == 0) begin
          $display("%0t: unexpected kept point idx=%0d x=%0d y=%0d end=%0b",
                   $time, kept_index, kept_x, kept_y, run_end);
          errors <= errors + 1;
        end else begin
          e = kept_q.pop_front();
          if (e.idx !== kept_index || e.x !== kept_x || e.y !== kept_y ||
              e.last !== run_end) begin
            $display("%0t: kept point mismatch exp idx=%0d x=%0d y=%0d end=%0b",
                     $time, e.idx, e.x, e.y, e.last);
            $display("%0t:                     got idx=%0d x=%0d y=%0d end=%0b",
                     $time, kept_index, kept_x, kept_y, run_end);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/polyline_simplify_rdp_test.sv
// Top of the polyline simplifier testbench: drives polylines and tolerance
// settings with random idling, and gives the verdict.
// Depends on polyline_simplify_rdp, polyline_simplify_rdp_check and polyrdp_pkg.
module polyline_simplify_rdp_test;
  import polyrdp_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic        [TOL_W-1:0]   cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic                      final_point = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic        [IDX_W-1:0]   kept_index;
  logic signed [COORD_W-1:0] kept_x;
  logic signed [COORD_W-1:0] kept_y;
  logic                      run_end;
  int                        errors, pending;
  int                        runs_sent = 0, runs_done = 0, points_sent = 0;
  int                        stall_left = 0, quiet_cycles = 0;
  bit                        calm = 1'b0;
  int                        walk_x, walk_y;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  polyline_simplify_rdp dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .point_x(point_x),
    .point_y(point_y), .final_point(final_point), .out_valid(out_valid),
    .out_ready(out_ready), .kept_index(kept_index), .kept_x(kept_x),
    .kept_y(kept_y), .run_end(run_end)
  );

  polyline_simplify_rdp_check check (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .point_x(point_x),
    .point_y(point_y), .final_point(final_point), .out_valid(out_valid),
    .out_ready(out_ready), .kept_index(kept_index), .kept_x(kept_x),
    .kept_y(kept_y), .run_end(run_end), .errors(errors), .pending(pending)
  );

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(7) == 0) begin
      stall_left <= $urandom_range(18);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready && run_end) begin
        runs_done <= runs_done + 1;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles > 40000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_point(input int x, input int y, input bit fin);
    point_x     <= x[COORD_W-1:0];
    point_y     <= y[COORD_W-1:0];
    final_point <= fin;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    points_sent++;
    if (fin) runs_sent++;
    if (!calm && $urandom_range(5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic finish_in();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (runs_done != runs_sent) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_tolerance(input int v);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= v[TOL_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int clamp16(input int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic int rand16();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // random walk with a step scale picked per polyline
  task automatic send_polyline(input int len);
    int scale, i, r;
    scale = 1 << $urandom_range(15);
    walk_x = rand16();
    walk_y = rand16();
    for (i = 0; i < len; i++) begin
      r = $urandom_range(15);
      if (r == 0) begin
        walk_x = rand16();
        walk_y = rand16();
      end else if (r == 1) begin
        walk_x = ($urandom_range(1)) ? 32767 : -32768;
      end else begin
        walk_x = clamp16(walk_x + int'($urandom_range(2 * scale)) - scale);
        walk_y = clamp16(walk_y + int'($urandom_range(2 * scale)) - scale);
      end
      send_point(walk_x, walk_y, i == len - 1);
    end
    finish_in();
  endtask

  task automatic random_phase(input int goal);
    int len, r;
    while (points_sent < goal) begin
      r = $urandom_range(19);
      if (r == 0) len = 64;
      else if (r == 1) len = $urandom_range(65, 70);
      else if (r == 2) len = 1;
      else len = $urandom_range(2, 12);
      send_polyline(len);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // single point, two points, extremes
    send_point(-32768, 32767, 1'b1);
    send_point(32767, -32768, 1'b0);
    send_point(-32768, 32767, 1'b1);
    // collinear line: interior points dropped
    send_point(0, 0, 1'b0);
    send_point(16, 16, 1'b0);
    send_point(32, 32, 1'b0);
    send_point(48, 48, 1'b1);
    // closed loop with coinciding endpoints
    send_point(100, 100, 1'b0);
    send_point(400, 100, 1'b0);
    send_point(400, 400, 1'b0);
    send_point(100, 100, 1'b1);
    // tie between two equally far points
    send_point(0, 0, 1'b0);
    send_point(160, 320, 1'b0);
    send_point(320, 320, 1'b0);
    send_point(480, 0, 1'b1);
    // exactly on the tolerance and just past it
    send_point(0, 0, 1'b0);
    send_point(160, 16, 1'b0);
    send_point(320, 17, 1'b0);
    send_point(480, 0, 1'b1);
    // extreme corners
    send_point(-32768, -32768, 1'b0);
    send_point(32767, -32768, 1'b0);
    send_point(32767, 32767, 1'b0);
    send_point(-32768, 32767, 1'b1);
    finish_in();
    set_tolerance(1);
    random_phase(90);
    set_tolerance(65535);
    random_phase(150);
    set_tolerance($urandom_range(2, 4000));
    random_phase(220);
    set_tolerance(16);
    random_phase(290);
    calm = 1'b1;
    set_tolerance($urandom_range(1, 200));
    random_phase(360);
    wait_idle();
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
